@@ sv/thpc_pkg.sv @@
`default_nettype none
package thpc_pkg;

  // queue between the front and back parts
  localparam int QDEPTH = 4;

  // quotient bits of the pressure divider
  localparam int Q_W = 36;
  // magnitude widths of the pressure numerator, the scaled numerator and the divisor
  localparam int M_W = 62;
  localparam int N_W = M_W + 12;
  localparam int V_W = 39;
  // back pipeline stages ahead of and after the divider
  localparam int PRE_STG = 9;
  localparam int POST_STG = 4;

  localparam logic [Q_W-1:0] Q_LIMIT = Q_W'(64'h8_0000_0000);
  localparam logic signed [32:0] PRESS_MAX = 33'sd33554431;
  localparam logic signed [61:0] HUM_MAX = 62'sd419430400;
  localparam logic [16:0] HUM_TOP = 17'd102400;

  // configuration register index
  typedef enum logic [2:0] {
    REG_TEMP_TRIM = 3'd0,
    REG_PRESS_A   = 3'd1,
    REG_PRESS_B   = 3'd2,
    REG_PRESS_C   = 3'd3,
    REG_HUM_TRIM  = 3'd4
  } reg_idx_t;

  // unpacked trim coefficients
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } trim_t;

  // request handed from front to back
  typedef struct packed {
    logic signed [21:0] tf;
    logic        [19:0] adc_p;
    logic        [15:0] adc_h;
  } item_t;

  // results riding alongside the divider
  typedef struct packed {
    logic               neg;
    logic               guard;
    logic               ovf;
    logic signed [15:0] temp;
    logic        [16:0] hum;
  } side_t;

endpackage
`default_nettype wire

@@ sv/thpc_fifo.sv @@
`default_nettype none
module thpc_fifo #(
  parameter int DEPTH = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  wr_en,
  input  thpc_pkg::item_t      wdata,
  input  wire                  rd_en,
  output thpc_pkg::item_t      rdata,
  output logic                 full,
  output logic                 empty
);
  import thpc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t           slot_r [0:DEPTH-1];
  logic [AW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = slot_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wp_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/thpc_front.sv @@
`default_nettype none
module thpc_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  thpc_pkg::trim_t      trim,
  input  wire                  push,
  output logic                 full,
  input  wire  [19:0]          raw_t,
  input  wire  [19:0]          raw_p,
  input  wire  [15:0]          raw_h,
  input  wire                  q_full,
  output logic                 q_wr,
  output thpc_pkg::item_t      q_item
);
  import thpc_pkg::*;

  logic [2:0]          vf_r;
  logic                adv;
  logic signed [17:0]  diff;
  logic signed [16:0]  d;
  logic signed [33:0]  pa_nxt, dd_nxt;
  logic signed [37:0]  b0_nxt;
  logic signed [24:0]  sum_nxt;
  logic signed [33:0]  f1_pa_r;
  logic [32:0]         f1_dd_r;
  logic [19:0]         f1_ap_r, f2_ap_r;
  logic [15:0]         f1_ah_r, f2_ah_r;
  logic signed [22:0]  f2_a_r;
  logic signed [37:0]  f2_b0_r;
  item_t               f3_item_r;

  assign adv    = !vf_r[2] || !q_full;
  assign full   = !adv;
  assign q_wr   = vf_r[2] && !q_full;
  assign q_item = f3_item_r;

  // fine temperature terms
  assign diff   = 18'($signed({1'b0, raw_t[19:3]})) - 18'($signed({1'b0, trim.t1, 1'b0}));
  assign d      = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, trim.t1});
  assign pa_nxt = diff * trim.t2;
  assign dd_nxt = d * d;
  assign b0_nxt = $signed({1'b0, f1_dd_r[32:12]}) * trim.t3;
  assign sum_nxt = 25'(f2_a_r) + 25'($signed(f2_b0_r[37:14]));

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= '0;
    end else if (adv) begin
      vf_r <= {vf_r[1:0], push};
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    if (adv) begin
      f1_pa_r <= pa_nxt;
      f1_dd_r <= dd_nxt[32:0];
      f1_ap_r <= raw_p;
      f1_ah_r <= raw_h;
      f2_a_r  <= $signed(f1_pa_r[33:11]);
      f2_b0_r <= b0_nxt;
      f2_ap_r <= f1_ap_r;
      f2_ah_r <= f1_ah_r;
      if (sum_nxt > 25'sd2097151) begin
        f3_item_r.tf <= 22'sh1FFFFF;
      end else if (sum_nxt < -25'sd2097152) begin
        f3_item_r.tf <= 22'sh200000;
      end else begin
        f3_item_r.tf <= sum_nxt[21:0];
      end
      f3_item_r.adc_p <= f2_ap_r;
      f3_item_r.adc_h <= f2_ah_r;
    end
  end

endmodule
`default_nettype wire

@@ sv/thpc_back.sv @@
`default_nettype none
module thpc_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  thpc_pkg::trim_t      trim,
  input  wire                  q_empty,
  input  thpc_pkg::item_t      q_item,
  output logic                 q_rd,
  output logic                 empty,
  input  wire                  pop,
  output logic signed [15:0]   temperature_centi,
  output logic [24:0]          pressure_q24_8,
  output logic [16:0]          humidity_q10,
  output logic                 pressure_guard
);
  import thpc_pkg::*;

  localparam int NSTG = PRE_STG + Q_W + POST_STG;

  logic [NSTG-1:0]     v_r;
  logic                adv;

  // stage 1 logic
  logic signed [22:0]  x_nxt, hv_nxt;
  logic signed [45:0]  xx_full;
  logic signed [38:0]  xp5_nxt, xp2_nxt;
  logic signed [34:0]  h5v_nxt;
  logic signed [30:0]  vh6_nxt;
  logic signed [31:0]  vh3_nxt;
  logic signed [24:0]  t5_nxt;
  logic signed [16:0]  tsh;
  logic signed [15:0]  temp_nxt;
  logic [42:0]         s1_xx_r;
  logic signed [38:0]  s1_xp5_r, s1_xp2_r;
  logic signed [34:0]  s1_h5v_r;
  logic signed [30:0]  s1_vh6_r;
  logic signed [31:0]  s1_vh3_r;
  logic [19:0]         s1_ap_r;
  logic [15:0]         s1_ah_r;
  logic signed [15:0]  s1_temp_r;

  // stage 2
  logic signed [36:0]  left_sum;
  logic signed [21:0]  vh3s;
  logic signed [59:0]  s2_ya_r, s2_za_r;
  logic signed [38:0]  s2_xp5_r, s2_xp2_r;
  logic signed [21:0]  s2_left_r;
  logic signed [42:0]  s2_inner0_r;
  logic [19:0]         s2_ap_r;
  logic signed [15:0]  s2_temp_r;

  // stage 3
  logic signed [33:0]  inner_b;
  logic signed [60:0]  s3_y_r;
  logic signed [53:0]  s3_a_r;
  logic signed [49:0]  s3_right0_r;
  logic signed [21:0]  s3_left_r;
  logic [19:0]         s3_ap_r;
  logic signed [15:0]  s3_temp_r;

  // stage 4
  logic [20:0]         pdiff;
  logic signed [50:0]  rsum;
  logic signed [53:0]  s4_denhi_r;
  logic [32:0]         s4_denlo_r;
  logic signed [61:0]  s4_num_r;
  logic signed [36:0]  s4_right_r;
  logic signed [21:0]  s4_left_r;
  logic signed [15:0]  s4_temp_r;

  // stage 5
  logic signed [54:0]  dsum;
  logic signed [38:0]  s5_den_r;
  logic [M_W-1:0]      s5_m_r;
  logic                s5_nneg_r;
  logic signed [58:0]  s5_vh_r;
  logic signed [15:0]  s5_temp_r;

  // stage 6
  logic signed [43:0]  hs;
  logic [43:0]         ms;
  logic [V_W-1:0]      s6_v_r;
  logic                s6_neg_r, s6_grd_r;
  logic [N_W-1:0]      s6_nn_r;
  logic signed [58:0]  s6_vh_r;
  logic [43:0]         s6_pphh_r, s6_pphl_r, s6_ppll_r;
  logic signed [15:0]  s6_temp_r;

  // stage 7
  logic [N_W-Q_W-1:0]  nhi;
  logic [V_W-1:0]      s7_rem_r, s7_v_r;
  logic [Q_W-1:0]      s7_nlo_r;
  logic                s7_neg_r, s7_grd_r, s7_ovf_r;
  logic [63:0]         s7_sq_r;
  logic signed [58:0]  s7_vh_r;
  logic signed [15:0]  s7_temp_r;

  // stage 8
  logic [64:0]         cprod;
  logic [V_W-1:0]      s8_rem_r, s8_v_r;
  logic [Q_W-1:0]      s8_nlo_r;
  logic                s8_neg_r, s8_grd_r, s8_ovf_r;
  logic [59:0]         s8_corr_r;
  logic signed [58:0]  s8_vh_r;
  logic signed [15:0]  s8_temp_r;

  // stage 9 and divider
  logic signed [61:0]  hd;
  logic [16:0]         hum_nxt;
  logic [V_W-1:0]      d_rem_r [0:Q_W];
  logic [V_W-1:0]      d_v_r   [0:Q_W];
  logic [Q_W-1:0]      d_nlo_r [0:Q_W];
  logic [Q_W-1:0]      d_q_r   [0:Q_W];
  side_t               d_sd_r  [0:Q_W];

  // post divider
  logic [Q_W-1:0]      qsat;
  logic signed [36:0]  p1_p_r;
  side_t               p1_sd_r;
  logic signed [47:0]  phph;
  logic signed [52:0]  e2f;
  logic signed [36:0]  p2_p_r;
  logic [44:0]         p2_phph_r;
  logic signed [33:0]  p2_e2_r;
  side_t               p2_sd_r;
  logic signed [61:0]  e1f;
  logic signed [36:0]  p3_p_r;
  logic signed [36:0]  p3_e1_r;
  logic signed [33:0]  p3_e2_r;
  side_t               p3_sd_r;
  logic signed [39:0]  psum;
  logic signed [32:0]  pf;
  logic [24:0]         press_nxt;
  logic signed [15:0]  p4_temp_r;
  logic [24:0]         p4_press_r;
  logic [16:0]         p4_hum_r;
  logic                p4_grd_r;

  // handshake: whole pipe moves when the output slot frees
  assign adv   = !v_r[NSTG-1] || pop;
  assign q_rd  = adv && !q_empty;
  assign empty = !v_r[NSTG-1];

  assign temperature_centi = p4_temp_r;
  assign pressure_q24_8    = p4_press_r;
  assign humidity_q10      = p4_hum_r;
  assign pressure_guard    = p4_grd_r;

  // stage 1: offsets from fine temperature, first products
  assign x_nxt   = 23'(q_item.tf) - 23'sd128000;
  assign hv_nxt  = 23'(q_item.tf) - 23'sd76800;
  assign xx_full = x_nxt * x_nxt;
  assign xp5_nxt = x_nxt * trim.p5;
  assign xp2_nxt = x_nxt * trim.p2;
  assign h5v_nxt = trim.h5 * hv_nxt;
  assign vh6_nxt = hv_nxt * trim.h6;
  assign vh3_nxt = hv_nxt * $signed({1'b0, trim.h3});
  assign t5_nxt  = 25'(q_item.tf) * 25'sd5 + 25'sd128;
  assign tsh     = $signed(t5_nxt[24:8]);
  assign temp_nxt = (tsh > 17'sd32767) ? 16'sh7FFF :
                    (tsh < -17'sd32768) ? 16'sh8000 : tsh[15:0];

  // stage 2 terms
  assign left_sum = 37'($signed({1'b0, s1_ah_r, 14'd0})) - (37'(trim.h4) <<< 20)
                    - 37'(s1_h5v_r) + 37'sd16384;
  assign vh3s     = 22'($signed(s1_vh3_r[31:11])) + 22'sd32768;

  // stage 3 terms
  assign inner_b = 34'($signed(s2_inner0_r[42:10])) + 34'sd2097152;

  // stage 4 terms
  assign pdiff = 21'h100000 - 21'(s3_ap_r);
  assign rsum  = 51'(s3_right0_r) + 51'sd8192;

  // stage 5 terms
  assign dsum = 55'(s4_denhi_r) + 55'($signed({1'b0, s4_denlo_r[32:17]}));

  // stage 6 terms
  assign hs = $signed(s5_vh_r[58:15]);
  assign ms = hs[43] ? 44'(-hs) : 44'(hs);

  // stage 7 terms
  assign nhi = s6_nn_r[N_W-1:Q_W];

  // stage 8 terms
  assign cprod = 65'(s7_sq_r[63:7]) * 65'(trim.h1);

  // stage 9 humidity clamp
  assign hd = 62'(s8_vh_r) - 62'($signed({1'b0, s8_corr_r}));
  assign hum_nxt = (hd < 62'sd0) ? 17'd0 : (hd > HUM_MAX) ? HUM_TOP : hd[28:12];

  // pre divider stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_xx_r     <= xx_full[42:0];
      s1_xp5_r    <= xp5_nxt;
      s1_xp2_r    <= xp2_nxt;
      s1_h5v_r    <= h5v_nxt;
      s1_vh6_r    <= vh6_nxt;
      s1_vh3_r    <= vh3_nxt;
      s1_ap_r     <= q_item.adc_p;
      s1_ah_r     <= q_item.adc_h;
      s1_temp_r   <= temp_nxt;

      s2_ya_r     <= $signed({1'b0, s1_xx_r}) * trim.p6;
      s2_za_r     <= $signed({1'b0, s1_xx_r}) * trim.p3;
      s2_xp5_r    <= s1_xp5_r;
      s2_xp2_r    <= s1_xp2_r;
      s2_left_r   <= $signed(left_sum[36:15]);
      s2_inner0_r <= $signed(s1_vh6_r[30:10]) * vh3s;
      s2_ap_r     <= s1_ap_r;
      s2_temp_r   <= s1_temp_r;

      s3_y_r      <= 61'(s2_ya_r) + (61'(s2_xp5_r) <<< 17) + (61'(trim.p4) <<< 35);
      s3_a_r      <= 54'($signed(s2_za_r[59:8])) + (54'(s2_xp2_r) <<< 12)
                     + 54'sd140737488355328;
      s3_right0_r <= inner_b * trim.h2;
      s3_left_r   <= s2_left_r;
      s3_ap_r     <= s2_ap_r;
      s3_temp_r   <= s2_temp_r;

      s4_denhi_r  <= $signed(s3_a_r[53:17]) * $signed({1'b0, trim.p1});
      s4_denlo_r  <= s3_a_r[16:0] * trim.p1;
      s4_num_r    <= (62'($signed({1'b0, pdiff})) <<< 31) - 62'(s3_y_r);
      s4_right_r  <= $signed(rsum[50:14]);
      s4_left_r   <= s3_left_r;
      s4_temp_r   <= s3_temp_r;

      s5_den_r    <= $signed(dsum[54:16]);
      s5_m_r      <= s4_num_r[61] ? M_W'(-s4_num_r) : M_W'(s4_num_r);
      s5_nneg_r   <= s4_num_r[61];
      s5_vh_r     <= s4_left_r * s4_right_r;
      s5_temp_r   <= s4_temp_r;

      s6_v_r      <= s5_den_r[38] ? V_W'(-s5_den_r) : V_W'(s5_den_r);
      s6_neg_r    <= s5_nneg_r ^ s5_den_r[38];
      s6_grd_r    <= (s5_den_r == '0);
      s6_nn_r     <= N_W'(s5_m_r) * N_W'(3125);
      s6_vh_r     <= s5_vh_r;
      s6_pphh_r   <= ms[43:22] * ms[43:22];
      s6_pphl_r   <= ms[43:22] * ms[21:0];
      s6_ppll_r   <= ms[21:0] * ms[21:0];
      s6_temp_r   <= s5_temp_r;

      s7_rem_r    <= V_W'(nhi);
      s7_ovf_r    <= (V_W'(nhi) >= s6_v_r);
      s7_nlo_r    <= s6_nn_r[Q_W-1:0];
      s7_v_r      <= s6_v_r;
      s7_neg_r    <= s6_neg_r;
      s7_grd_r    <= s6_grd_r;
      s7_sq_r     <= (64'(s6_pphh_r) << 44) + (64'(s6_pphl_r) << 23) + 64'(s6_ppll_r);
      s7_vh_r     <= s6_vh_r;
      s7_temp_r   <= s6_temp_r;

      s8_rem_r    <= s7_rem_r;
      s8_v_r      <= s7_v_r;
      s8_nlo_r    <= s7_nlo_r;
      s8_neg_r    <= s7_neg_r;
      s8_grd_r    <= s7_grd_r;
      s8_ovf_r    <= s7_ovf_r;
      s8_corr_r   <= cprod[63:4];
      s8_vh_r     <= s7_vh_r;
      s8_temp_r   <= s7_temp_r;

      d_rem_r[0]  <= s8_rem_r;
      d_v_r[0]    <= s8_v_r;
      d_nlo_r[0]  <= s8_nlo_r;
      d_q_r[0]    <= '0;
      d_sd_r[0].neg   <= s8_neg_r;
      d_sd_r[0].guard <= s8_grd_r;
      d_sd_r[0].ovf   <= s8_ovf_r;
      d_sd_r[0].temp  <= s8_temp_r;
      d_sd_r[0].hum   <= hum_nxt;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar i = 0; i < Q_W; i++) begin : g_div
    logic [V_W:0] rt;
    logic [V_W:0] rdiff;
    logic         ge;
    assign rt    = {d_rem_r[i], d_nlo_r[i][Q_W-1-i]};
    assign rdiff = rt - {1'b0, d_v_r[i]};
    assign ge    = (rt >= {1'b0, d_v_r[i]});
    always_ff @(posedge clk) begin
      if (adv) begin
        d_rem_r[i+1] <= ge ? rdiff[V_W-1:0] : rt[V_W-1:0];
        d_q_r[i+1]   <= {d_q_r[i][Q_W-2:0], ge};
        d_v_r[i+1]   <= d_v_r[i];
        d_nlo_r[i+1] <= d_nlo_r[i];
        d_sd_r[i+1]  <= d_sd_r[i];
      end
    end
  end

  // post divider correction terms
  assign qsat = (d_sd_r[Q_W].ovf || d_q_r[Q_W] > Q_LIMIT) ? Q_LIMIT : d_q_r[Q_W];
  assign phph = $signed(p1_p_r[36:13]) * $signed(p1_p_r[36:13]);
  assign e2f  = trim.p8 * p1_p_r;
  assign e1f  = trim.p9 * $signed({1'b0, p2_phph_r});
  assign psum = 40'(p3_p_r) + 40'(p3_e1_r) + 40'(p3_e2_r);
  assign pf   = 33'($signed(psum[39:8])) + (33'(trim.p7) <<< 4);
  assign press_nxt = (p3_sd_r.guard || pf < 33'sd0) ? 25'd0 :
                     (pf > PRESS_MAX) ? PRESS_MAX[24:0] : pf[24:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_p_r    <= d_sd_r[Q_W].neg ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
      p1_sd_r   <= d_sd_r[Q_W];
      p2_p_r    <= p1_p_r;
      p2_phph_r <= phph[44:0];
      p2_e2_r   <= $signed(e2f[52:19]);
      p2_sd_r   <= p1_sd_r;
      p3_p_r    <= p2_p_r;
      p3_e1_r   <= $signed(e1f[61:25]);
      p3_e2_r   <= p2_e2_r;
      p3_sd_r   <= p2_sd_r;
      p4_temp_r <= p3_sd_r.temp;
      p4_hum_r  <= p3_sd_r.hum;
      p4_grd_r  <= p3_sd_r.guard;
      p4_press_r <= press_nxt;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], !q_empty};
    end
  end

endmodule
`default_nettype wire

@@ sv/thp_sensor_compensation.sv @@
// Compensation of raw temperature, pressure and humidity readings.
// Input channel: a request of three raw readings enters when push is high and
// full is low. Result channel: while empty is low the oldest result sits on
// the out_ ports and leaves when pop is high.
// Trim coefficients are written over the APB-style port at byte 8*i for
// register i and read back from prdata; write them only while idle.
// Throughput: one request per cycle while full is low. From acceptance to
// empty going low a request passes 3 fine-temperature stages, the first
// loaded at the accepting edge, the queue, then 49 back stages of which 36
// are the one-bit-per-stage pressure divider.
// A short queue parts the fine-temperature front from the back pipeline.
// When the receiver stalls the back pipeline holds, the queue fills, then
// the front holds and full rises; nothing is dropped.
// Reset clears the trim registers, all valid bits and the queue: the block
// comes up empty and ready.
`default_nettype none
module thp_sensor_compensation #(
  parameter int QDEPTH = thpc_pkg::QDEPTH
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  output logic               full,
  input  wire  [19:0]        in_raw_temperature,
  input  wire  [19:0]        in_raw_pressure,
  input  wire  [15:0]        in_raw_humidity,
  output logic               empty,
  input  wire                pop,
  output logic signed [15:0] out_temperature_centi,
  output logic [24:0]        out_pressure_q24_8,
  output logic [16:0]        out_humidity_q10,
  output logic               out_pressure_guard,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [5:0]         paddr,
  input  wire  [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import thpc_pkg::*;

  logic [47:0] temp_trim_r;
  logic [63:0] press_a_r, press_b_r, hum_trim_r;
  logic [15:0] press_c_r;
  logic        wr_req;
  trim_t       trim;
  logic        q_wr, q_rd, q_full, q_empty;
  item_t       q_wdata, q_rdata;

  assign pready = 1'b1;
  assign wr_req = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_trim_r <= '0;
      press_a_r   <= '0;
      press_b_r   <= '0;
      press_c_r   <= '0;
      hum_trim_r  <= '0;
    end else if (wr_req) begin
      case (paddr[5:3])
        REG_TEMP_TRIM: temp_trim_r <= pwdata[47:0];
        REG_PRESS_A:   press_a_r   <= pwdata;
        REG_PRESS_B:   press_b_r   <= pwdata;
        REG_PRESS_C:   press_c_r   <= pwdata[15:0];
        REG_HUM_TRIM:  hum_trim_r  <= pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[5:3])
      REG_TEMP_TRIM: prdata = 64'(temp_trim_r);
      REG_PRESS_A:   prdata = press_a_r;
      REG_PRESS_B:   prdata = press_b_r;
      REG_PRESS_C:   prdata = 64'(press_c_r);
      REG_HUM_TRIM:  prdata = hum_trim_r;
      default:       prdata = '0;
    endcase
  end

  // coefficient unpacking
  assign trim.t1 = temp_trim_r[15:0];
  assign trim.t2 = temp_trim_r[31:16];
  assign trim.t3 = temp_trim_r[47:32];
  assign trim.p1 = press_a_r[15:0];
  assign trim.p2 = press_a_r[31:16];
  assign trim.p3 = press_a_r[47:32];
  assign trim.p4 = press_a_r[63:48];
  assign trim.p5 = press_b_r[15:0];
  assign trim.p6 = press_b_r[31:16];
  assign trim.p7 = press_b_r[47:32];
  assign trim.p8 = press_b_r[63:48];
  assign trim.p9 = press_c_r;
  assign trim.h1 = hum_trim_r[7:0];
  assign trim.h2 = hum_trim_r[23:8];
  assign trim.h3 = hum_trim_r[31:24];
  assign trim.h4 = hum_trim_r[43:32];
  assign trim.h5 = hum_trim_r[55:44];
  assign trim.h6 = hum_trim_r[63:56];

  thpc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .trim   (trim),
    .push   (push),
    .full   (full),
    .raw_t  (in_raw_temperature),
    .raw_p  (in_raw_pressure),
    .raw_h  (in_raw_humidity),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_item (q_wdata)
  );

  thpc_fifo #(.DEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (q_wr),
    .wdata (q_wdata),
    .rd_en (q_rd),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  thpc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .trim              (trim),
    .q_empty           (q_empty),
    .q_item            (q_rdata),
    .q_rd              (q_rd),
    .empty             (empty),
    .pop               (pop),
    .temperature_centi (out_temperature_centi),
    .pressure_q24_8    (out_pressure_q24_8),
    .humidity_q10      (out_humidity_q10),
    .pressure_guard    (out_pressure_guard)
  );

  // checks
  a_q_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr |-> !q_full) else $error("front wrote into a full queue");
  a_q_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> !q_empty) else $error("back read an empty queue");
  a_guard_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_pressure_guard) |-> (out_pressure_q24_8 == '0))
    else $error("guarded pressure not zero");
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_humidity_q10 <= HUM_TOP)) else $error("humidity above 100 percent");

endmodule
`default_nettype wire
